@@ sv/efb_pkg.sv @@
// Shared types, constants and helpers of the event fragment builder.
package efb_pkg;

  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned DEST_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EVICT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SOURCES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_INCOMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DEST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_OFFSET  = 3'd6;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    logic [TICK_W-1:0]  start;
  } entry_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [DEST_W-1:0]   dest;
    logic                dec;
  } result_t;

  typedef struct packed {
    logic arrive;
    logic tick;
    logic load;
    logic step;
    logic keep;
    logic pop;
  } tbl_cmd_t;

  typedef struct packed {
    logic head_complete;
    logic head_expired;
    logic evict_due;
    logic scan_done;
  } tbl_sts_t;

  typedef struct packed {
    logic                emit;
    logic [STATUS_W-1:0] status;
    logic                flush;
    logic                div_start;
  } sch_cmd_t;

  typedef struct packed {
    logic dec_ok;
  } sch_sts_t;

  // v mod d for v < 16, 1 <= d <= 16: four restoring subtract steps
  function automatic logic [DEST_W-1:0] mod_small(input logic [DEST_W-1:0] v,
                                                  input logic [4:0] d);
    logic [7:0] r;
    logic [7:0] s;
    r = {4'd0, v};
    for (int k = 3; k >= 0; k--) begin
      s = {3'd0, d} << k;
      if (r >= s) r = r - s;
    end
    return r[DEST_W-1:0];
  endfunction

endpackage

@@ sv/efb_table.sv @@
// Sorted table of open frames: lookup, insert, rotate-scan and eviction.
module efb_table #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  efb_pkg::tbl_cmd_t            cmd,
  input  logic [efb_pkg::FRAME_W-1:0]  frame_in,
  input  logic [7:0]                   num_sources,
  input  logic [19:0]                  timeout_ms,
  input  logic [4:0]                   depth_limit,
  output logic [efb_pkg::FRAME_W-1:0]  head_frame,
  output logic [efb_pkg::COUNT_W-1:0]  head_count,
  output efb_pkg::tbl_sts_t            sts
);

  localparam int CW = $clog2(DEPTH + 1);

  efb_pkg::entry_t ent_r   [DEPTH];
  efb_pkg::entry_t ent_nxt [DEPTH];
  efb_pkg::entry_t up      [DEPTH];
  efb_pkg::entry_t dn      [DEPTH];
  efb_pkg::entry_t new_ent;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [efb_pkg::TICK_W-1:0] now_r, now_nxt;
  logic [efb_pkg::TICK_W-1:0] age;

  logic [DEPTH-1:0] hit, lt, prev_lt;
  logic any_hit;

  // entries stay compacted at the low end, ascending frame number
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (i < int'(cnt_r)) && (ent_r[i].frame == frame_in);
      lt[i]  = (i < int'(cnt_r)) && (ent_r[i].frame < frame_in);
    end
    prev_lt[0] = 1'b1;
    for (int i = 1; i < DEPTH; i++) prev_lt[i] = lt[i-1];
    any_hit = |hit;

    new_ent.frame = frame_in;
    new_ent.count = efb_pkg::COUNT_W'(1);
    new_ent.start = now_r;

    for (int i = 0; i < DEPTH - 1; i++) up[i] = ent_r[i+1];
    up[DEPTH-1] = ent_r[0];
    dn[0] = new_ent;
    for (int i = 1; i < DEPTH; i++) dn[i] = ent_r[i-1];

    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (cmd.arrive) begin
        if (any_hit) begin
          if (hit[i] && ent_r[i].count != 8'hFF) ent_nxt[i].count = ent_r[i].count + 8'd1;
        end else if (!lt[i]) begin
          ent_nxt[i] = prev_lt[i] ? new_ent : dn[i];
        end
      end else if (cmd.step || cmd.pop) begin
        if (i + 1 < int'(cnt_r)) begin
          ent_nxt[i] = up[i];
        end else if (i + 1 == int'(cnt_r) && cmd.step && cmd.keep) begin
          ent_nxt[i] = ent_r[0];
        end
      end
    end

    cnt_nxt = cnt_r;
    if (cmd.arrive && !any_hit) cnt_nxt = cnt_r + CW'(1);
    else if ((cmd.step && !cmd.keep) || cmd.pop) cnt_nxt = cnt_r - CW'(1);

    scan_nxt = scan_r;
    if (cmd.load) scan_nxt = cnt_r;
    else if (cmd.step) scan_nxt = scan_r - CW'(1);

    now_nxt = cmd.tick ? now_r + 32'd1 : now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      scan_r <= '0;
      now_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      scan_r <= scan_nxt;
      now_r  <= now_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
  end

  assign age        = now_r - ent_r[0].start;
  assign head_frame = ent_r[0].frame;
  assign head_count = ent_r[0].count;

  always_comb begin
    sts.head_complete = (ent_r[0].count == num_sources);
    sts.head_expired  = (age > {12'd0, timeout_ms});
    sts.evict_due     = ((depth_limit != 5'd0) && (32'(cnt_r) > 32'(depth_limit)))
                        || (cnt_r == CW'(DEPTH));
    sts.scan_done     = (scan_r == '0);
  end

endmodule

@@ sv/efb_sched.sv @@
// Result stage: destination, decimation phase, remainder unit and output beats.
module efb_sched (
  input  logic                          clk,
  input  logic                          rst_n,
  input  efb_pkg::sch_cmd_t             cmd,
  output efb_pkg::sch_sts_t             sts,
  input  logic [efb_pkg::FRAME_W-1:0]   head_frame,
  input  logic [efb_pkg::COUNT_W-1:0]   head_count,
  input  logic [4:0]                    num_destinations,
  input  logic [15:0]                   decimation_factor,
  input  logic [15:0]                   decimation_offset,
  input  logic                          factor_wr,
  output logic                          out_valid,
  output efb_pkg::result_t              out_res,
  output logic                          out_last
);

  logic [efb_pkg::DEST_W-1:0] next_dest_r;
  logic [31:0] sent_r;
  logic [15:0] phase_r;
  logic        ok_r;
  logic        div_busy_r;
  logic [4:0]  div_cnt_r;
  logic [15:0] div_rem_r;
  logic [31:0] div_sh_r;
  logic        pend_v_r;
  efb_pkg::result_t pend_r;
  logic        out_valid_r;
  efb_pkg::result_t out_r;
  logic        out_last_r;

  logic [4:0]  nd;
  logic [efb_pkg::DEST_W-1:0] dest;
  logic [4:0]  dest_inc;
  logic [15:0] off;
  logic        dec;
  logic [16:0] phase_inc;
  logic [16:0] div_t;
  logic [15:0] div_rem_nxt;
  efb_pkg::result_t new_res;

  always_comb begin
    if (num_destinations == 5'd0) nd = 5'd1;
    else if (num_destinations > 5'd16) nd = 5'd16;
    else nd = num_destinations;
    dest     = efb_pkg::mod_small(next_dest_r, nd);
    dest_inc = {1'b0, dest} + 5'd1;
    off      = (decimation_offset < decimation_factor) ? decimation_offset : 16'd0;
    dec      = (decimation_factor != 16'd0) && (phase_r == off);
    phase_inc = {1'b0, phase_r} + 17'd1;
    new_res.frame  = head_frame;
    new_res.status = cmd.status;
    new_res.count  = head_count;
    new_res.dest   = dest;
    new_res.dec    = dec;
    // restoring step; remainder stays below the divisor
    div_t = {div_rem_r, div_sh_r[31]};
    if (div_t >= {1'b0, decimation_factor}) div_rem_nxt = 16'(div_t - {1'b0, decimation_factor});
    else div_rem_nxt = div_t[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_dest_r <= '0;
      sent_r      <= '0;
      phase_r     <= '0;
      ok_r        <= 1'b1;
      div_busy_r  <= 1'b0;
      div_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      if (factor_wr) begin
        ok_r <= 1'b0;
      end else if (cmd.div_start) begin
        if (decimation_factor == 16'd0) begin
          ok_r    <= 1'b1;
          phase_r <= '0;
        end else begin
          div_busy_r <= 1'b1;
          div_cnt_r  <= '0;
        end
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          div_busy_r <= 1'b0;
          ok_r       <= 1'b1;
          phase_r    <= div_rem_nxt;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b1;
        next_dest_r <= (dest_inc == nd) ? '0 : dest_inc[efb_pkg::DEST_W-1:0];
        sent_r      <= sent_r + 32'd1;
        // sent count wraps to zero, whose remainder is zero
        if (sent_r == 32'hFFFF_FFFF || phase_inc == {1'b0, decimation_factor}) phase_r <= '0;
        else phase_r <= phase_inc[15:0];
      end else if (cmd.flush) begin
        out_valid_r <= pend_v_r;
        out_last_r  <= 1'b1;
        pend_v_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= '0;
      div_sh_r  <= sent_r;
    end else if (div_busy_r) begin
      div_rem_r <= div_rem_nxt;
      div_sh_r  <= {div_sh_r[30:0], 1'b0};
    end
    if (cmd.emit) begin
      pend_r <= new_res;
      out_r  <= pend_r;
    end else if (cmd.flush) begin
      out_r <= pend_r;
    end
  end

  assign sts.dec_ok = ok_r;
  assign out_valid  = out_valid_r;
  assign out_res    = out_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/efb_ctrl.sv @@
// Controller: sequences arrival, scan, eviction and the final beat of each item.
module efb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               operation,
  input  logic               emit_incomplete,
  input  efb_pkg::tbl_sts_t  tbl_sts,
  input  efb_pkg::sch_sts_t  sch_sts,
  output efb_pkg::tbl_cmd_t  tbl_cmd,
  output efb_pkg::sch_cmd_t  sch_cmd,
  output logic               busy
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_DIV   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_EVICT = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    tbl_cmd   = '0;
    sch_cmd   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          tbl_cmd.arrive = !operation;
          tbl_cmd.tick   = operation;
          state_nxt      = S_PREP;
        end
      end
      S_PREP: begin
        tbl_cmd.load = 1'b1;
        if (!sch_sts.dec_ok) begin
          sch_cmd.div_start = 1'b1;
          state_nxt         = S_DIV;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_DIV: begin
        if (sch_sts.dec_ok) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tbl_sts.scan_done) begin
          state_nxt = S_EVICT;
        end else begin
          tbl_cmd.step = 1'b1;
          if (tbl_sts.head_complete) begin
            sch_cmd.emit   = 1'b1;
            sch_cmd.status = efb_pkg::ST_COMPLETE;
          end else if (tbl_sts.head_expired) begin
            sch_cmd.emit   = emit_incomplete;
            sch_cmd.status = efb_pkg::ST_TIMEOUT;
          end else begin
            tbl_cmd.keep = 1'b1;
          end
        end
      end
      S_EVICT: begin
        if (tbl_sts.evict_due) begin
          tbl_cmd.pop    = 1'b1;
          sch_cmd.emit   = emit_incomplete;
          sch_cmd.status = efb_pkg::ST_EVICT;
        end
        state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        sch_cmd.flush = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/event_fragment_builder.sv @@
// Top level of the event fragment builder: config registers, controller and datapath.
// An item (fragment arrival or tick) is taken when start is high and busy is low and
// then passes through the lookup/insert in the accept cycle, a setup state, the
// ascending scan through the sorted table over the open frames left after the arrival,
// a check for the end of the scan, eviction and the last beat; busy is high from the
// setup state through the last beat, and the next item can be taken after that.
// The first item after a write of a nonzero decimation_factor also waits for the 32-step
// remainder unit that rebuilds the decimation phase. Results come as one-cycle out_valid
// beats that the receiver must take; out_last marks the final beat of an item, and an
// item may give none.
module event_fragment_builder #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_frame_number,
  output logic        out_valid,
  output logic [31:0] out_frame_number_out,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fragment_count,
  output logic [3:0]  out_destination,
  output logic        out_decimate_copy,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [7:0]  num_sources_r;
  logic [19:0] timeout_ms_r;
  logic [4:0]  depth_limit_r;
  logic        emit_incomplete_r;
  logic [4:0]  num_destinations_r;
  logic [15:0] decimation_factor_r;
  logic [15:0] decimation_offset_r;

  efb_pkg::tbl_cmd_t tbl_cmd;
  efb_pkg::tbl_sts_t tbl_sts;
  efb_pkg::sch_cmd_t sch_cmd;
  efb_pkg::sch_sts_t sch_sts;
  efb_pkg::result_t  out_res;
  logic [31:0] head_frame;
  logic [7:0]  head_count;
  logic        accept;
  logic        factor_wr;

  assign accept    = start && !busy;
  assign factor_wr = cfg_we && (cfg_index == efb_pkg::CFG_DEC_FACTOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sources_r       <= 8'd1;
      timeout_ms_r        <= 20'd10000;
      depth_limit_r       <= 5'd31;
      emit_incomplete_r   <= 1'b0;
      num_destinations_r  <= 5'd1;
      decimation_factor_r <= 16'd0;
      decimation_offset_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        efb_pkg::CFG_NUM_SOURCES: num_sources_r       <= cfg_data[7:0];
        efb_pkg::CFG_TIMEOUT:     timeout_ms_r        <= cfg_data;
        efb_pkg::CFG_DEPTH_LIMIT: depth_limit_r       <= cfg_data[4:0];
        efb_pkg::CFG_EMIT_INCOMP: emit_incomplete_r   <= cfg_data[0];
        efb_pkg::CFG_NUM_DEST:    num_destinations_r  <= cfg_data[4:0];
        efb_pkg::CFG_DEC_FACTOR:  decimation_factor_r <= cfg_data[15:0];
        efb_pkg::CFG_DEC_OFFSET:  decimation_offset_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  efb_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .operation       (in_operation),
    .emit_incomplete (emit_incomplete_r),
    .tbl_sts         (tbl_sts),
    .sch_sts         (sch_sts),
    .tbl_cmd         (tbl_cmd),
    .sch_cmd         (sch_cmd),
    .busy            (busy)
  );

  efb_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (tbl_cmd),
    .frame_in    (in_frame_number),
    .num_sources (num_sources_r),
    .timeout_ms  (timeout_ms_r),
    .depth_limit (depth_limit_r),
    .head_frame  (head_frame),
    .head_count  (head_count),
    .sts         (tbl_sts)
  );

  efb_sched u_sched (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (sch_cmd),
    .sts               (sch_sts),
    .head_frame        (head_frame),
    .head_count        (head_count),
    .num_destinations  (num_destinations_r),
    .decimation_factor (decimation_factor_r),
    .decimation_offset (decimation_offset_r),
    .factor_wr         (factor_wr),
    .out_valid         (out_valid),
    .out_res           (out_res),
    .out_last          (out_last)
  );

  assign out_frame_number_out = out_res.frame;
  assign out_status           = out_res.status;
  assign out_fragment_count   = out_res.count;
  assign out_destination      = out_res.dest;
  assign out_decimate_copy    = out_res.dec;

  // beats only come out of work started by an accepted item
  a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without an item in progress");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("beat follows the last beat of an item");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("last beat while item still in progress");

endmodule
